[src/spq_pkg.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_pkg: shared types and constants of the sorted priority queue
// Opcodes, fixed field widths and the control word broadcast to the cells.
// ---------------------------------------------------------------------------
package spq_pkg;

    // fixed field widths
    localparam int KEY_W = 32;
    localparam int CAP_W = 11;
    localparam int OP_W  = 2;

    localparam logic [CAP_W-1:0] CAP_RESET = 11'd1024;

    // operation codes; code three is unused, changes nothing and is answered with ok low
    typedef enum logic [OP_W-1:0] {
        OP_PUSH  = 2'd0,
        OP_POP   = 2'd1,
        OP_CLEAR = 2'd2
    } t_opcode;

    // per-cycle command broadcast along the cell chain
    typedef struct packed {
        logic push;
        logic pop;
    } t_cell_ctrl;

endpackage

[src/spq_cell.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// spq_cell: one slot of the sorted chain
// Holds one entry. On push it keeps its entry, takes the new one, or takes
// its left neighbor's; on pop it takes its right neighbor's entry.
// ---------------------------------------------------------------------------
module spq_cell
    import spq_pkg::*;
#(
    parameter int COORD_BITS = 12
) (
    input  logic                  i_clk,
    input  t_cell_ctrl            i_ctrl,
    input  logic                  i_valid,     // slot lies below the fill count
    input  logic [COORD_BITS-1:0] i_new_row,
    input  logic [COORD_BITS-1:0] i_new_col,
    input  logic [KEY_W-1:0]      i_new_key,
    input  logic                  i_left_gt,   // left neighbor moves right
    input  logic [COORD_BITS-1:0] i_left_row,
    input  logic [COORD_BITS-1:0] i_left_col,
    input  logic [KEY_W-1:0]      i_left_key,
    input  logic [COORD_BITS-1:0] i_right_row,
    input  logic [COORD_BITS-1:0] i_right_col,
    input  logic [KEY_W-1:0]      i_right_key,
    output logic                  o_gt,
    output logic [COORD_BITS-1:0] o_row,
    output logic [COORD_BITS-1:0] o_col,
    output logic [KEY_W-1:0]      o_key
);

    logic [COORD_BITS-1:0] r_row, n_row;
    logic [COORD_BITS-1:0] r_col, n_col;
    logic [KEY_W-1:0]      r_key, n_key;

    // an empty slot or a strictly larger key yields its place to the new entry
    assign o_gt = !i_valid || (r_key > i_new_key);

    // slot update
    always_comb begin
        n_row = r_row;
        n_col = r_col;
        n_key = r_key;
        if (i_ctrl.push && o_gt) begin
            if (i_left_gt) begin
                n_row = i_left_row;
                n_col = i_left_col;
                n_key = i_left_key;
            end else begin
                n_row = i_new_row;
                n_col = i_new_col;
                n_key = i_new_key;
            end
        end else if (i_ctrl.pop) begin
            n_row = i_right_row;
            n_col = i_right_col;
            n_key = i_right_key;
        end
    end

    always_ff @(posedge i_clk) begin
        r_row <= n_row;
        r_col <= n_col;
        r_key <= n_key;
    end

    assign o_row = r_row;
    assign o_col = r_col;
    assign o_key = r_key;

endmodule

[src/sorted_priority_queue.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// sorted_priority_queue: bounded min-priority queue of pixel coordinates
// Systolic sorted list: a row of DEPTH cells, smallest key in cell 0, equal
// keys kept in arrival order. Push inserts in place, pop shifts left.
//
// channel    | dir | tdata (low bit up)              | tuser
// s_axis     | in  | row, column, key                | opcode
// m_axis     | out | out_row, out_column, out_key,   | ok
//            |     | occupancy                       |
// cfg        | in  | i_cfg_wdata = capacity          | -
//
// One operation per cycle: every cell compares its key against the pushed
// key in the cycle the transaction is accepted, and the result lands in the
// output register on the next edge.
// A result waiting in the output register blocks input until it is taken;
// input and output can move in the same cycle.
// Reset empties the queue and sets capacity to 1024; cell contents are not
// cleared, only slots below the count are ever read.
// ---------------------------------------------------------------------------
module sorted_priority_queue
    import spq_pkg::*;
#(
    parameter int DEPTH      = 1024,
    parameter int COORD_BITS = 12,
    localparam int IN_W      = 2 * COORD_BITS + KEY_W,
    localparam int IN_DW     = ((IN_W + 7) / 8) * 8,
    localparam int OUT_W     = 2 * COORD_BITS + KEY_W + CAP_W,
    localparam int OUT_DW    = ((OUT_W + 7) / 8) * 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // configuration
    input  logic              i_cfg_wen,
    input  logic [CAP_W-1:0]  i_cfg_wdata,    // capacity
    // operation stream
    input  logic              s_axis_tvalid,
    output logic              s_axis_tready,
    input  logic [IN_DW-1:0]  s_axis_tdata,   // row, column, key
    input  logic [OP_W-1:0]   s_axis_tuser,   // opcode
    // result stream
    output logic              m_axis_tvalid,
    input  logic              m_axis_tready,
    output logic [OUT_DW-1:0] m_axis_tdata,   // out_row, out_column, out_key, occupancy
    output logic [0:0]        m_axis_tuser    // ok
);

    logic [CAP_W-1:0] r_cap;
    logic [CAP_W-1:0] r_count, n_count;

    logic                  r_out_valid;
    logic                  r_ok, n_ok;
    logic [COORD_BITS-1:0] r_res_row, n_res_row;
    logic [COORD_BITS-1:0] r_res_col, n_res_col;
    logic [KEY_W-1:0]      r_res_key, n_res_key;

    logic                  w_acc;
    t_opcode               w_op;
    logic [COORD_BITS-1:0] w_in_row;
    logic [COORD_BITS-1:0] w_in_col;
    logic [KEY_W-1:0]      w_in_key;
    logic                  w_room;
    logic                  w_nonempty;
    t_cell_ctrl            w_ctrl;

    logic [DEPTH-1:0]      w_valid;
    logic [DEPTH-1:0]      w_gt;
    logic [COORD_BITS-1:0] w_row [DEPTH];
    logic [COORD_BITS-1:0] w_col [DEPTH];
    logic [KEY_W-1:0]      w_key [DEPTH];

    // input unpack
    assign w_acc    = s_axis_tvalid && s_axis_tready;
    assign w_op     = t_opcode'(s_axis_tuser);
    assign w_in_row = s_axis_tdata[COORD_BITS-1:0];
    assign w_in_col = s_axis_tdata[2*COORD_BITS-1:COORD_BITS];
    assign w_in_key = s_axis_tdata[IN_W-1:2*COORD_BITS];

    // room and fill state
    assign w_room     = (32'(r_count) < 32'(r_cap)) && (32'(r_count) < DEPTH);
    assign w_nonempty = (r_count != '0);

    // capacity register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cap <= CAP_RESET;
        end else if (i_cfg_wen) begin
            r_cap <= i_cfg_wdata;
        end
    end

    // operation decode and result
    always_comb begin
        w_ctrl    = '0;
        n_count   = r_count;
        n_ok      = 1'b0;
        n_res_row = '0;
        n_res_col = '0;
        n_res_key = '0;
        unique case (w_op)
            OP_PUSH: begin
                if (w_room) begin
                    w_ctrl.push = w_acc;
                    n_count     = r_count + 1'b1;
                    n_ok        = 1'b1;
                end
            end
            OP_POP: begin
                if (w_nonempty) begin
                    w_ctrl.pop = w_acc;
                    n_count    = r_count - 1'b1;
                    n_ok       = 1'b1;
                    n_res_row  = w_row[0];
                    n_res_col  = w_col[0];
                    n_res_key  = w_key[0];
                end
            end
            OP_CLEAR: begin
                n_count = '0;
                n_ok    = 1'b1;
            end
            default: begin
                n_ok = 1'b0;
            end
        endcase
    end

    // fill count and output valid
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_acc) begin
                r_count <= n_count;
            end
            if (w_acc) begin
                r_out_valid <= 1'b1;
            end else if (m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // result payload
    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r_ok      <= n_ok;
            r_res_row <= n_res_row;
            r_res_col <= n_res_col;
            r_res_key <= n_res_key;
        end
    end

    // cell chain
    for (genvar gi = 0; gi < DEPTH; gi++) begin : g_cell
        logic                  w_lgt;
        logic [COORD_BITS-1:0] w_lrow, w_lcol, w_rrow, w_rcol;
        logic [KEY_W-1:0]      w_lkey, w_rkey;

        assign w_valid[gi] = (32'(gi) < 32'(r_count));

        if (gi == 0) begin : g_head
            assign w_lgt  = 1'b0;
            assign w_lrow = w_in_row;
            assign w_lcol = w_in_col;
            assign w_lkey = w_in_key;
        end else begin : g_body
            assign w_lgt  = w_gt[gi-1];
            assign w_lrow = w_row[gi-1];
            assign w_lcol = w_col[gi-1];
            assign w_lkey = w_key[gi-1];
        end

        if (gi == DEPTH - 1) begin : g_tail
            assign w_rrow = w_row[gi];
            assign w_rcol = w_col[gi];
            assign w_rkey = w_key[gi];
        end else begin : g_mid
            assign w_rrow = w_row[gi+1];
            assign w_rcol = w_col[gi+1];
            assign w_rkey = w_key[gi+1];
        end

        spq_cell #(
            .COORD_BITS (COORD_BITS)
        ) u_cell (
            .i_clk       (i_clk),
            .i_ctrl      (w_ctrl),
            .i_valid     (w_valid[gi]),
            .i_new_row   (w_in_row),
            .i_new_col   (w_in_col),
            .i_new_key   (w_in_key),
            .i_left_gt   (w_lgt),
            .i_left_row  (w_lrow),
            .i_left_col  (w_lcol),
            .i_left_key  (w_lkey),
            .i_right_row (w_rrow),
            .i_right_col (w_rcol),
            .i_right_key (w_rkey),
            .o_gt        (w_gt[gi]),
            .o_row       (w_row[gi]),
            .o_col       (w_col[gi]),
            .o_key       (w_key[gi])
        );
    end

    // handshake and output pack
    assign s_axis_tready = !r_out_valid || m_axis_tready;
    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tuser  = r_ok;
    assign m_axis_tdata  = OUT_DW'({r_count, r_res_key, r_res_col, r_res_row});

    // checks
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= DEPTH)
        else $error("fill count above depth");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_PUSH && w_room) |=> r_count == $past(r_count) + 1'b1)
        else $error("stored push did not grow the count");

    a_clear_empties: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_CLEAR) |=> r_count == '0)
        else $error("clear left entries");

    a_pop_sorted: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_acc && w_op == OP_POP && 32'(r_count) > 1) |=> r_res_key <= w_key[0])
        else $error("popped key larger than new head");

endmodule
